### hdl/hsec_pkg.sv
// shared types, constants and helper functions for the hamming sec encoder/decoder
// no dependencies; imported by hsec_cfg_regs and hamming_sec_encode_decode
package hsec_pkg;

  localparam int WordW  = 63;
  localparam int FieldW = 6;

  localparam logic FN_ENCODE = 1'b0;
  localparam logic FN_DECODE = 1'b1;

  localparam logic REG_DATA_BITS = 1'b0;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_FIXED  = 2'd1,
    ST_UNCORR = 2'd2
  } err_status_t;

  typedef struct packed {
    logic [FieldW-1:0] m;
    logic [FieldW-1:0] n;
  } code_cfg_t;

  function automatic logic [2:0] check_count(input logic [FieldW-1:0] m, input int max_r);
    logic [2:0] r;
    logic       found;
    r     = 3'(max_r);
    found = 1'b0;
    for (int i = 1; i <= 6; i++) begin
      if (!found && (i <= max_r) && (8'(1 << i) >= (8'(m) + 8'(i) + 8'd1))) begin
        r     = 3'(i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  // codeword position (from 1) of data bit d
  function automatic int data_pos(input int d);
    int cnt;
    int pos;
    cnt = 0;
    pos = 0;
    for (int k = 1; k <= WordW; k++) begin
      if ((k & (k - 1)) != 0) begin
        if ((cnt == d) && (pos == 0)) pos = k;
        cnt++;
      end
    end
    return pos;
  endfunction

endpackage

### hdl/hsec_cfg_regs.sv
// apb-style configuration register for the data length, plus derived code geometry
// depends on hsec_pkg
module hsec_cfg_regs #(
  parameter int MAX_CHECK_BITS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output hsec_pkg::code_cfg_t cfg
);
  import hsec_pkg::*;

  localparam int MaxM = (1 << MAX_CHECK_BITS) - MAX_CHECK_BITS - 1;

  logic [FieldW-1:0] data_bits_r;
  logic [FieldW-1:0] data_bits_nxt;
  logic [FieldW-1:0] m_eff;
  logic [2:0]        r_eff;

  assign pready = 1'b1;

  always_comb begin
    data_bits_nxt = data_bits_r;
    if (psel && penable && pwrite && (paddr[2] == REG_DATA_BITS)) begin
      data_bits_nxt = pwdata[FieldW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bits_r <= 6'd4;
    end else begin
      data_bits_r <= data_bits_nxt;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_DATA_BITS) prdata = {26'd0, data_bits_r};
  end

  always_comb begin
    m_eff = data_bits_r;
    if (m_eff == 6'd0) m_eff = 6'd1;
    if (m_eff > 6'(MaxM)) m_eff = 6'(MaxM);
    r_eff = check_count(m_eff, MAX_CHECK_BITS);
  end

  assign cfg.m = m_eff;
  assign cfg.n = m_eff + 6'(r_eff);

endmodule

### hdl/hamming_sec_encode_decode.sv
// top level: four-stage even-parity hamming sec encoder and single-error corrector
// depends on hsec_pkg and hsec_cfg_regs
//
// One beat per cycle in each direction unless the output stalls; outputs come from the register of
// stage 4. Stages: bit placement and length masking, syndrome xor trees, check-bit insertion
// or single-bit correction, data extraction. Each stage has its own valid bit and advances
// whenever the stage below is empty or moving, so a stalled output only holds the beats
// behind it. The data length register may only be written while no beat is in flight.
module hamming_sec_encode_decode #(
  parameter int MAX_CHECK_BITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [62:0] in_word_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [62:0] out_word_out,
  output logic [5:0]  out_code_length,
  output logic [5:0]  out_error_position,
  output logic [1:0]  out_error_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hsec_pkg::*;

  localparam int P    = MAX_CHECK_BITS;
  localparam int MaxM = (1 << P) - P - 1;

  typedef struct packed {
    logic              func;
    logic [WordW-1:0]  code;
    logic [FieldW-1:0] m;
    logic [FieldW-1:0] n;
  } s1_t;

  typedef struct packed {
    logic              func;
    logic [WordW-1:0]  code;
    logic [P-1:0]      syn;
    logic [FieldW-1:0] m;
    logic [FieldW-1:0] n;
  } s2_t;

  typedef struct packed {
    logic              func;
    logic [WordW-1:0]  code;
    logic [P-1:0]      syn;
    err_status_t       status;
    logic [FieldW-1:0] m;
    logic [FieldW-1:0] n;
  } s3_t;

  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [FieldW-1:0] n;
    logic [FieldW-1:0] pos;
    err_status_t       status;
  } s4_t;

  code_cfg_t cfg;

  hsec_cfg_regs #(
    .MAX_CHECK_BITS(MAX_CHECK_BITS)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready),
    .cfg    (cfg)
  );

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // placement or length mask
  always_comb begin
    s1_nxt      = '0;
    s1_nxt.func = in_func;
    s1_nxt.m    = cfg.m;
    s1_nxt.n    = cfg.n;
    if (in_func == FN_ENCODE) begin
      for (int d = 0; d < MaxM; d++) begin
        if (6'(d) < cfg.m) s1_nxt.code[data_pos(d) - 1] = in_word_in[d];
      end
    end else begin
      for (int k = 1; k <= WordW; k++) begin
        s1_nxt.code[k-1] = in_word_in[k-1] & (6'(k) <= cfg.n);
      end
    end
  end

  // syndrome
  always_comb begin
    s2_nxt      = '0;
    s2_nxt.func = s1_r.func;
    s2_nxt.code = s1_r.code;
    s2_nxt.m    = s1_r.m;
    s2_nxt.n    = s1_r.n;
    for (int i = 0; i < P; i++) begin
      for (int k = 1; k <= WordW; k++) begin
        if (((k >> i) & 1) != 0) s2_nxt.syn[i] = s2_nxt.syn[i] ^ s1_r.code[k-1];
      end
    end
  end

  // check-bit insertion or correction
  always_comb begin
    s3_nxt        = '0;
    s3_nxt.func   = s2_r.func;
    s3_nxt.code   = s2_r.code;
    s3_nxt.syn    = s2_r.syn;
    s3_nxt.m      = s2_r.m;
    s3_nxt.n      = s2_r.n;
    s3_nxt.status = ST_NONE;
    if (s2_r.func == FN_ENCODE) begin
      for (int i = 0; i < P; i++) begin
        s3_nxt.code[(1 << i) - 1] = s2_r.code[(1 << i) - 1] | s2_r.syn[i];
      end
    end else if (s2_r.syn == '0) begin
      s3_nxt.status = ST_NONE;
    end else if (6'(s2_r.syn) <= s2_r.n) begin
      s3_nxt.status = ST_FIXED;
      for (int k = 1; k <= WordW; k++) begin
        if (6'(s2_r.syn) == 6'(k)) s3_nxt.code[k-1] = ~s2_r.code[k-1];
      end
    end else begin
      s3_nxt.status = ST_UNCORR;
    end
  end

  // extraction
  always_comb begin
    s4_nxt        = '0;
    s4_nxt.n      = s3_r.n;
    s4_nxt.status = s3_r.status;
    if (s3_r.func == FN_ENCODE) begin
      s4_nxt.word = s3_r.code;
    end else begin
      s4_nxt.pos = 6'(s3_r.syn);
      for (int d = 0; d < MaxM; d++) begin
        if (6'(d) < s3_r.m) s4_nxt.word[d] = s3_r.code[data_pos(d) - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
    if (en3) s3_r <= s3_nxt;
    if (en4) s4_r <= s4_nxt;
  end

  assign out_valid          = v4_r;
  assign out_word_out       = s4_r.word;
  assign out_code_length    = s4_r.n;
  assign out_error_position = s4_r.pos;
  assign out_error_status   = s4_r.status;

`ifndef ASSERT_OFF
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (!v4_r || out_ready) |-> in_ready)
    else $error("input stalled although output stage is free");

  a_fixed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && (s4_r.status == ST_FIXED)) |-> ((s4_r.pos != 6'd0) && (s4_r.pos <= s4_r.n)))
    else $error("corrected position outside code length");

  a_none_zero_syn: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && (s4_r.status == ST_NONE)) |-> (s4_r.pos == 6'd0))
    else $error("no-error status with nonzero syndrome");

  a_uncorr_beyond: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && (s4_r.status == ST_UNCORR)) |-> (s4_r.pos > s4_r.n))
    else $error("uncorrectable status with syndrome inside code length");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && v4_r && !out_ready) |=> (v3_r && $stable(s3_r)))
    else $error("stage three beat lost while output stalled");
`endif

endmodule
